FILE: rtl/gmwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmwc_pkg: shared types and constants of the multiply-with-carry generator
// Configuration layout, command word, engine status and reset values.
// ----------------------------------------------------------------------------
package gmwc_pkg;

    // Order of the recurrence: lags at or beyond this depth carry no weight.
    localparam int          LAG_DEPTH  = 3;
    localparam logic [1:0]  OLDEST_IDX = 2'(LAG_DEPTH - 1);

    localparam logic [63:0] STATE_RESET     = 64'd12345;
    localparam logic [63:0] COEF_LAG3_RESET = 64'd28459776973178;

    typedef enum logic [2:0] {
        CFG_COEF_LAG1      = 3'd0,
        CFG_COEF_LAG2      = 3'd1,
        CFG_COEF_LAG3      = 3'd2,
        CFG_LEAD_MAGNITUDE = 3'd3,
        CFG_LEAD_INVERSE   = 3'd4,
        CFG_CARRY_ADDS     = 3'd5,
        CFG_OUTPUT_MODE    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OUT_NEWEST     = 2'd0,
        OUT_XOR_OLDEST = 2'd1,
        OUT_XOR_SECOND = 2'd2,
        OUT_FRESH      = 2'd3
    } t_out_mode;

    typedef struct packed {
        logic [63:0] coef_lag1;
        logic [63:0] coef_lag2;
        logic [63:0] coef_lag3;
        logic [63:0] lead_magnitude;
        logic [63:0] lead_inverse;
        logic        carry_adds;
        t_out_mode   output_mode;
    } t_cfg;

    typedef struct packed {
        logic        is_reseed;
        logic [63:0] seed;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic calc;
        logic at_last;
    } t_eng_stat;

endpackage

FILE: rtl/general_mwc_rng_order3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// general_mwc_rng_order3: multiply-with-carry random word generator
// Each generate word yields one 64-bit random word; a reseed word loads every
// lag and the carry and yields nothing. Input words go into a two-entry queue,
// so the source can send ahead while the engine works and while a finished
// word waits in the output register. A generate word occupies the engine while
// one 32x32 multiplier forms the nineteen partial products of the lag,
// inverse and magnitude multiplications one per cycle, a drain step after each
// group and a commit step. A reseed word is applied while idle. Configuration
// must be written by the user only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module general_mwc_rng_order3 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [63:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_random_word,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import gmwc_pkg::*;

    t_cfg      r_cfg;
    t_cmd      q_cmd;
    logic      q_valid;
    logic      q_take;
    t_eng_stat eng_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_lag1      <= 64'd0;
            r_cfg.coef_lag2      <= 64'd0;
            r_cfg.coef_lag3      <= COEF_LAG3_RESET;
            r_cfg.lead_magnitude <= 64'd1;
            r_cfg.lead_inverse   <= 64'd1;
            r_cfg.carry_adds     <= 1'b0;
            r_cfg.output_mode    <= OUT_NEWEST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_LAG1:      r_cfg.coef_lag1      <= i_cfg_data;
                CFG_COEF_LAG2:      r_cfg.coef_lag2      <= i_cfg_data;
                CFG_COEF_LAG3:      r_cfg.coef_lag3      <= i_cfg_data;
                CFG_LEAD_MAGNITUDE: r_cfg.lead_magnitude <= i_cfg_data;
                CFG_LEAD_INVERSE:   r_cfg.lead_inverse   <= i_cfg_data;
                CFG_CARRY_ADDS:     r_cfg.carry_adds     <= i_cfg_data[0];
                CFG_OUTPUT_MODE:    r_cfg.output_mode    <= t_out_mode'(i_cfg_data[1:0]);
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    gmwc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_op         (i_op),
        .i_seed_value (i_seed_value),
        .o_stall      (o_stall),
        .o_valid      (q_valid),
        .o_cmd        (q_cmd),
        .i_take       (q_take)
    );

    gmwc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_take  (q_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_random_word),
        .o_stat      (eng_stat)
    );

    // Once started, a step runs through to its commit cycle.
    a_calc_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.calc && !eng_stat.at_last |=> eng_stat.calc)
        else $error("engine left a step before its commit cycle");

    // A commit with room at the output always presents a word next cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.at_last && !(o_valid && i_stall) |=> o_valid && eng_stat.idle)
        else $error("commit did not load the output register");

    // A new word appears only out of a commit cycle.
    a_word_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(eng_stat.at_last))
        else $error("output word appeared without a commit");

endmodule

FILE: rtl/gmwc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmwc_front: input word queue
// Accepts input words, tags them as reseed or generate, and holds up to two
// of them for the engine.
// ----------------------------------------------------------------------------
module gmwc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_op,
    input  logic [63:0]   i_seed_value,
    output logic          o_stall,
    output logic          o_valid,
    output gmwc_pkg::t_cmd o_cmd,
    input  logic          i_take
);
    import gmwc_pkg::*;

    localparam logic [1:0] Q_DEPTH = 2'd2;

    t_cmd       r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       pop;
    t_cmd       in_cmd;

    assign o_stall = (r_count == Q_DEPTH);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    assign push = i_valid && !o_stall;
    assign pop  = i_take && o_valid;

    assign in_cmd.is_reseed = i_op;
    assign in_cmd.seed      = i_seed_value;

    always_comb begin
        unique case ({push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

FILE: rtl/gmwc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmwc_engine: recurrence sequencer
// Works one step of the recurrence through a single 32x32 multiplier, one
// partial product a cycle outside drain steps, into a 128-bit accumulator or
// a 64-bit fresh word, commits the lags and carry, loads the output register.
// ----------------------------------------------------------------------------
module gmwc_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gmwc_pkg::t_cfg     i_cfg,
    input  logic               i_cmd_valid,
    input  gmwc_pkg::t_cmd     i_cmd,
    output logic               o_cmd_take,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [63:0]        o_word,
    output gmwc_pkg::t_eng_stat o_stat
);
    import gmwc_pkg::*;

    // Step plan: lag products 0..11, drain 12, inverse products 13..15,
    // drain 16, magnitude products 17..20, drain 21, commit 22.
    localparam logic [4:0] STEP_LAG_END = 5'd12;
    localparam logic [4:0] STEP_INV     = 5'd13;
    localparam logic [4:0] STEP_INV_END = 5'd16;
    localparam logic [4:0] STEP_MAG     = 5'd17;
    localparam logic [4:0] STEP_MAG_END = 5'd21;
    localparam logic [4:0] STEP_LAST    = 5'd22;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } t_eng_state;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_64 = 2'd2
    } t_shift;

    t_eng_state   r_state;
    t_eng_state   n_state;
    logic [4:0]   r_step;
    logic [63:0]  r_lag [0:2];
    logic [63:0]  r_carry;
    logic [127:0] r_acc;
    logic [127:0] n_acc;
    logic [63:0]  r_fresh;
    logic [63:0]  n_fresh;
    logic         r_pp_valid;
    logic [63:0]  r_prod;
    t_shift       r_shift;
    logic         r_to_fresh;
    logic         r_sub;
    logic         r_out_valid;
    logic [63:0]  r_out_word;

    // Partial product selection for the current step.
    logic         pp_valid;
    logic [63:0]  a_word;
    logic [63:0]  b_word;
    logic [1:0]   part;
    logic [1:0]   lag;
    logic [4:0]   rel;
    logic         pp_to_fresh;
    logic         pp_sub;
    t_shift       pp_shift;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  mul_p;
    logic [127:0] shifted;

    logic         start;
    logic         reseed;
    logic         commit;
    logic         out_free;
    logic [63:0]  result;

    always_comb begin
        pp_valid    = 1'b0;
        a_word      = i_cfg.coef_lag1;
        b_word      = r_lag[0];
        part        = r_step[1:0];
        lag         = r_step[3:2];
        rel         = 5'd0;
        pp_to_fresh = 1'b0;
        pp_sub      = 1'b0;
        if (r_state == ST_CALC) begin
            priority if (r_step < STEP_LAG_END) begin
                unique case (lag)
                    2'd0: begin
                        a_word = i_cfg.coef_lag1;
                        b_word = r_lag[0];
                    end
                    2'd1: begin
                        a_word = i_cfg.coef_lag2;
                        b_word = r_lag[1];
                    end
                    default: begin
                        a_word = i_cfg.coef_lag3;
                        b_word = r_lag[2];
                    end
                endcase
                pp_valid = (lag <= OLDEST_IDX) && (lag != 2'd3);
            end else if (r_step >= STEP_INV && r_step < STEP_INV_END) begin
                rel         = r_step - STEP_INV;
                part        = rel[1:0];
                a_word      = i_cfg.lead_inverse;
                b_word      = r_acc[63:0];
                pp_to_fresh = 1'b1;
                pp_valid    = 1'b1;
            end else if (r_step >= STEP_MAG && r_step < STEP_MAG_END) begin
                rel      = r_step - STEP_MAG;
                part     = rel[1:0];
                a_word   = i_cfg.lead_magnitude;
                b_word   = r_fresh;
                pp_sub   = !i_cfg.carry_adds;
                pp_valid = 1'b1;
            end else begin
                pp_valid = 1'b0;
            end
        end
    end

    // part 0: low x low, 1: low x high, 2: high x low, 3: high x high
    always_comb begin
        unique case (part)
            2'd0: begin
                mul_a    = a_word[31:0];
                mul_b    = b_word[31:0];
                pp_shift = SH_0;
            end
            2'd1: begin
                mul_a    = a_word[31:0];
                mul_b    = b_word[63:32];
                pp_shift = SH_32;
            end
            2'd2: begin
                mul_a    = a_word[63:32];
                mul_b    = b_word[31:0];
                pp_shift = SH_32;
            end
            default: begin
                mul_a    = a_word[63:32];
                mul_b    = b_word[63:32];
                pp_shift = SH_64;
            end
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    always_comb begin
        unique case (r_shift)
            SH_0:    shifted = {64'b0, r_prod};
            SH_32:   shifted = {32'b0, r_prod, 32'b0};
            SH_64:   shifted = {r_prod, 64'b0};
            default: shifted = 128'b0;
        endcase
    end

    assign start    = (r_state == ST_IDLE) && i_cmd_valid && !i_cmd.is_reseed;
    assign reseed   = (r_state == ST_IDLE) && i_cmd_valid && i_cmd.is_reseed;
    assign out_free = !r_out_valid || !i_stall;
    assign commit   = (r_state == ST_CALC) && (r_step == STEP_LAST) && out_free;

    always_comb begin
        n_acc   = r_acc;
        n_fresh = r_fresh;
        if (start) begin
            n_acc   = {64'b0, r_carry};
            n_fresh = 64'b0;
        end else if (r_pp_valid) begin
            if (r_to_fresh) begin
                n_fresh = r_fresh + shifted[63:0];
            end else if (r_sub) begin
                n_acc = r_acc - shifted;
            end else begin
                n_acc = r_acc + shifted;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (i_cfg.output_mode)
            OUT_NEWEST:     result = r_lag[0];
            OUT_XOR_OLDEST: result = r_lag[0] ^ r_lag[OLDEST_IDX];
            OUT_XOR_SECOND: result = r_lag[0] ^ r_lag[1];
            OUT_FRESH:      result = r_fresh;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 5'd0;
            r_pp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lag[0]    <= STATE_RESET;
            r_lag[1]    <= STATE_RESET;
            r_lag[2]    <= STATE_RESET;
            r_carry     <= STATE_RESET;
        end else begin
            r_state    <= n_state;
            r_pp_valid <= pp_valid;
            if (start) begin
                r_step <= 5'd0;
            end else if (r_state == ST_CALC && r_step != STEP_LAST) begin
                r_step <= r_step + 5'd1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (reseed) begin
                r_lag[0] <= i_cmd.seed;
                r_lag[1] <= i_cmd.seed;
                r_lag[2] <= i_cmd.seed;
                r_carry  <= i_cmd.seed;
            end else if (commit) begin
                r_lag[2] <= r_lag[1];
                r_lag[1] <= r_lag[0];
                r_lag[0] <= r_fresh;
                r_carry  <= r_acc[127:64];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_fresh    <= n_fresh;
        r_prod     <= mul_p;
        r_shift    <= pp_shift;
        r_to_fresh <= pp_to_fresh;
        r_sub      <= pp_sub;
        if (commit) begin
            r_out_word <= result;
        end
    end

    assign o_cmd_take     = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_valid        = r_out_valid;
    assign o_word         = r_out_word;
    assign o_stat.idle    = (r_state == ST_IDLE);
    assign o_stat.calc    = (r_state == ST_CALC);
    assign o_stat.at_last = (r_state == ST_CALC) && (r_step == STEP_LAST);

endmodule
